// ----- src/mm4_pkg.sv -----
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared constants, types and operation codes of the 4x4 fixed point matrix
// multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

    // element format
    localparam int ELEM_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int PORT_BITS = 32;
    localparam int DIM       = 4;
    localparam int CELLS     = DIM * DIM;

    // derived widths
    localparam int PROD_BITS = 2 * ELEM_BITS;
    localparam int PAIR_BITS = PROD_BITS + 1;
    localparam int ACC_BITS  = PROD_BITS + 2;

    typedef logic signed [ELEM_BITS-1:0] elem_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;
    typedef logic signed [PAIR_BITS-1:0] pair_t;
    typedef logic signed [ACC_BITS-1:0]  acc_t;
    typedef logic [1:0]                  row_t;

    // saturation limits
    localparam elem_t ELEM_MAX = {1'b0, {(ELEM_BITS-1){1'b1}}};
    localparam elem_t ELEM_MIN = {1'b1, {(ELEM_BITS-1){1'b0}}};

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MUL  = 1'b1;

    // control that travels alongside each beat
    typedef struct packed {
        logic valid;
        row_t row;
    } ctl_t;

endpackage

// ----- src/matrix_multiply_4x4_top.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_top
// Streamed 4x4 signed fixed point matrix product, one left row per beat.
// ----------------------------------------------------------------------------
// Throughput is one beat per cycle unless a result waits with out_stall
// high: a load beat writes one row of the stored right-hand matrix and gives
// no result, a multiply beat gives one result row through a four-stage
// pipeline (products, two adder tree levels, shift and saturate). A load is
// seen by any multiply beat accepted after it. The stored matrix is zero after
// reset. The pipeline moves as a whole and holds while a result waits with
// out_stall high; in_stall is high exactly then.
module matrix_multiply_4x4_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [1:0]  in_row,
    input  logic [31:0] in_e0,
    input  logic [31:0] in_e1,
    input  logic [31:0] in_e2,
    input  logic [31:0] in_e3,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  out_row,
    output logic [31:0] out_e0,
    output logic [31:0] out_e1,
    output logic [31:0] out_e2,
    output logic [31:0] out_e3,
    output logic        saturated
);

    logic                                 en;
    logic                                 load_en;
    mm4_pkg::elem_t                       in_elem [mm4_pkg::DIM];
    mm4_pkg::elem_t                       mat     [mm4_pkg::CELLS];
    mm4_pkg::prod_t                       prod    [mm4_pkg::CELLS];
    mm4_pkg::acc_t                        acc     [mm4_pkg::DIM];
    logic signed [mm4_pkg::PORT_BITS-1:0] res     [mm4_pkg::DIM];
    mm4_pkg::ctl_t                        ctl_in;
    mm4_pkg::ctl_t                        ctl_m;
    mm4_pkg::ctl_t                        ctl_s;
    mm4_pkg::ctl_t                        ctl_o;

    // pipeline advance and input handshake
    assign en       = !(ctl_o.valid && out_stall);
    assign in_stall = !en;
    assign load_en  = in_valid && en && (op == mm4_pkg::OP_LOAD);

    // low element bits of each input beat
    assign in_elem[0] = in_e0[mm4_pkg::ELEM_BITS-1:0];
    assign in_elem[1] = in_e1[mm4_pkg::ELEM_BITS-1:0];
    assign in_elem[2] = in_e2[mm4_pkg::ELEM_BITS-1:0];
    assign in_elem[3] = in_e3[mm4_pkg::ELEM_BITS-1:0];

    // only multiply beats enter the pipeline
    assign ctl_in.valid = in_valid && (op == mm4_pkg::OP_MUL);
    assign ctl_in.row   = in_row;

    mm4_store u_store
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (load_en),
        .wr_row (in_row),
        .wr_e   (in_elem),
        .mat    (mat)
    );

    mm4_mult u_mult
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl_in),
        .left    (in_elem),
        .mat     (mat),
        .ctl_out (ctl_m),
        .prod    (prod)
    );

    mm4_sum u_sum
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl_m),
        .prod    (prod),
        .ctl_out (ctl_s),
        .acc     (acc)
    );

    mm4_sat u_sat
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl_s),
        .acc     (acc),
        .ctl_out (ctl_o),
        .res     (res),
        .sat     (saturated)
    );

    // result beat
    assign out_valid = ctl_o.valid;
    assign out_row   = ctl_o.row;
    assign out_e0    = res[0];
    assign out_e1    = res[1];
    assign out_e2    = res[2];
    assign out_e3    = res[3];

endmodule

// ----- src/mm4_store.sv -----
// ----------------------------------------------------------------------------
// mm4_store
// Right-hand matrix storage: one row written per load beat, cleared at reset.
// ----------------------------------------------------------------------------
module mm4_store
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  mm4_pkg::row_t  wr_row,
    input  mm4_pkg::elem_t wr_e [mm4_pkg::DIM],
    output mm4_pkg::elem_t mat  [mm4_pkg::CELLS]
);

    mm4_pkg::elem_t mat_reg [mm4_pkg::CELLS];

    // row write, element index is row * 4 + column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mm4_pkg::CELLS; i++)
            begin
                mat_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            for (int j = 0; j < mm4_pkg::DIM; j++)
            begin
                mat_reg[{wr_row, 2'(j)}] <= wr_e[j];
            end
        end
    end

    assign mat = mat_reg;

endmodule

// ----- src/mm4_mult.sv -----
// ----------------------------------------------------------------------------
// mm4_mult
// First pipeline stage: sixteen signed products of left row and stored matrix.
// ----------------------------------------------------------------------------
module mm4_mult
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  mm4_pkg::ctl_t  ctl_in,
    input  mm4_pkg::elem_t left [mm4_pkg::DIM],
    input  mm4_pkg::elem_t mat  [mm4_pkg::CELLS],
    output mm4_pkg::ctl_t  ctl_out,
    output mm4_pkg::prod_t prod [mm4_pkg::CELLS]
);

    mm4_pkg::ctl_t  ctl_reg;
    mm4_pkg::prod_t prod_reg  [mm4_pkg::CELLS];
    mm4_pkg::prod_t prod_next [mm4_pkg::CELLS];

    // product k*4+j is left[k] times stored[k][j]
    always_comb
    begin
        for (int i = 0; i < mm4_pkg::CELLS; i++)
        begin
            prod_next[i] = mm4_pkg::prod_t'(left[i / mm4_pkg::DIM])
                         * mm4_pkg::prod_t'(mat[i]);
        end
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    // product registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign prod    = prod_reg;

endmodule

// ----- src/mm4_sum.sv -----
// ----------------------------------------------------------------------------
// mm4_sum
// Second and third pipeline stages: two-level registered adder tree per column.
// ----------------------------------------------------------------------------
module mm4_sum
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  mm4_pkg::ctl_t  ctl_in,
    input  mm4_pkg::prod_t prod [mm4_pkg::CELLS],
    output mm4_pkg::ctl_t  ctl_out,
    output mm4_pkg::acc_t  acc  [mm4_pkg::DIM]
);

    mm4_pkg::ctl_t ctl_a_reg;
    mm4_pkg::ctl_t ctl_b_reg;
    mm4_pkg::pair_t pair_reg  [mm4_pkg::DIM][2];
    mm4_pkg::pair_t pair_next [mm4_pkg::DIM][2];
    mm4_pkg::acc_t  acc_reg   [mm4_pkg::DIM];
    mm4_pkg::acc_t  acc_next  [mm4_pkg::DIM];

    // first level: rows 0+1 and rows 2+3 of each column
    always_comb
    begin
        for (int j = 0; j < mm4_pkg::DIM; j++)
        begin
            for (int h = 0; h < 2; h++)
            begin
                pair_next[j][h] = mm4_pkg::pair_t'(prod[(2*h) * mm4_pkg::DIM + j])
                                + mm4_pkg::pair_t'(prod[(2*h+1) * mm4_pkg::DIM + j]);
            end
        end
    end

    // second level: full column sum
    always_comb
    begin
        for (int j = 0; j < mm4_pkg::DIM; j++)
        begin
            acc_next[j] = mm4_pkg::acc_t'(pair_reg[j][0])
                        + mm4_pkg::acc_t'(pair_reg[j][1]);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else if (en)
        begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_a_reg;
        end
    end

    // sum registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pair_reg <= pair_next;
            acc_reg  <= acc_next;
        end
    end

    assign ctl_out = ctl_b_reg;
    assign acc     = acc_reg;

endmodule

// ----- src/mm4_sat.sv -----
// ----------------------------------------------------------------------------
// mm4_sat
// Output stage: floor shift of each column sum, saturation, result register.
// ----------------------------------------------------------------------------
module mm4_sat
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  mm4_pkg::ctl_t                       ctl_in,
    input  mm4_pkg::acc_t                       acc  [mm4_pkg::DIM],
    output mm4_pkg::ctl_t                       ctl_out,
    output logic signed [mm4_pkg::PORT_BITS-1:0] res  [mm4_pkg::DIM],
    output logic                                sat
);

    localparam int TOP_BITS = mm4_pkg::ACC_BITS - mm4_pkg::ELEM_BITS + 1;

    mm4_pkg::ctl_t  ctl_reg;
    mm4_pkg::elem_t res_reg  [mm4_pkg::DIM];
    mm4_pkg::elem_t res_next [mm4_pkg::DIM];
    logic           sat_reg;
    logic           sat_next;

    // shift, range check and clip per column
    always_comb
    begin
        mm4_pkg::acc_t         sh;
        logic [TOP_BITS-1:0]   top;
        sat_next = 1'b0;
        for (int j = 0; j < mm4_pkg::DIM; j++)
        begin
            sh  = acc[j] >>> mm4_pkg::FRAC_BITS;
            top = sh[mm4_pkg::ACC_BITS-1:mm4_pkg::ELEM_BITS-1];
            if ((&top) || !(|top))
            begin
                res_next[j] = sh[mm4_pkg::ELEM_BITS-1:0];
            end
            else
            begin
                sat_next    = 1'b1;
                res_next[j] = sh[mm4_pkg::ACC_BITS-1] ? mm4_pkg::ELEM_MIN
                                                      : mm4_pkg::ELEM_MAX;
            end
        end
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    // sign extension to port width
    always_comb
    begin
        for (int j = 0; j < mm4_pkg::DIM; j++)
        begin
            res[j] = mm4_pkg::PORT_BITS'(res_reg[j]);
        end
    end

    assign ctl_out = ctl_reg;
    assign sat     = sat_reg;

endmodule
